// File: rtl/core/bnmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnmm_pkg: shared types and constants of the neighbourhood mean block
// Holds field widths, operation and register codes, the control and status
// bundles between controller and datapath, and the reciprocal table.
// ----------------------------------------------------------------------------
package bnmm_pkg;

  localparam int unsigned COORD_W     = 6;
  localparam int unsigned SIZE_W      = 7;
  localparam int unsigned COST_W      = 16;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned SUM_W       = 20;  // nine 16-bit costs
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  localparam logic [SIZE_W-1:0] SIZE_X_RST      = 7'd64;
  localparam logic [SIZE_W-1:0] SIZE_Y_RST      = 7'd64;
  localparam logic [COST_W-1:0] UPPER_LIMIT_RST = 16'd51200;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X      = 2'd0,
    CFG_SIZE_Y      = 2'd1,
    CFG_UPPER_LIMIT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic write_cell;  // store the accepted write beat
    logic capture;     // latch the query centre, clear the accumulators
    logic issue;       // read the current neighbour and advance
    logic mul;         // register sum times reciprocal of count
    logic load_out;    // copy the finished result to the output register
  } cmd_t;

  typedef struct packed {
    logic last_nb;     // current neighbour is the ninth
  } status_t;

  // ceil(2^24 / d): exact floor division for sums below 2^20
  function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    case (cnt)
      4'd1:    r = 25'd16777216;
      4'd2:    r = 25'd8388608;
      4'd3:    r = 25'd5592406;
      4'd4:    r = 25'd4194304;
      4'd5:    r = 25'd3355444;
      4'd6:    r = 25'd2796203;
      4'd7:    r = 25'd2396746;
      4'd8:    r = 25'd2097152;
      4'd9:    r = 25'd1864136;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/bnmm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnmm_ctrl: sequencer of the neighbourhood mean block
// Takes input beats, steps the datapath through the nine neighbour reads,
// the division and the hand-over to the output register.
// ----------------------------------------------------------------------------
module bnmm_ctrl
  import bnmm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    operation_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (op_e'(operation_i) == OP_QUERY) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_SCAN;
          end else begin
            cmd_o.write_cell = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_nb) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/bnmm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnmm_datapath: cost grid, neighbour scan, accumulation and division
// Holds the grid memory, the configuration registers, the running maximum
// and the output payload register.
// ----------------------------------------------------------------------------
module bnmm_datapath
  import bnmm_pkg::*;
#(
  parameter int unsigned GRID_COLS = 64,
  parameter int unsigned GRID_ROWS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [COORD_W-1:0]    cell_x_i,
  input  logic [COORD_W-1:0]    cell_y_i,
  input  logic [COST_W-1:0]     cell_value_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic [COST_W-1:0]     mean_cost_o,
  output logic [CNT_W-1:0]      accepted_count_o,
  output logic [COST_W-1:0]     running_max_o,
  output logic                  none_accepted_o
);

  localparam int unsigned DEPTH  = GRID_COLS * GRID_ROWS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [COST_W-1:0]  mem [DEPTH];

  logic [SIZE_W-1:0]  size_x_q, size_y_q;
  logic [COST_W-1:0]  upper_limit_q;
  logic [COST_W-1:0]  max_q;
  logic [1:0]         ox_q, oy_q;
  logic [COORD_W-1:0] cx_q, cy_q;
  logic               rd_vld_q;
  logic [COST_W-1:0]  rd_data_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PROD_W-1:0]  prod_q;

  logic [SIZE_W-1:0]  lim_x, lim_y;
  logic [SIZE_W-1:0]  nx_p1, ny_p1, nx, ny;
  logic               nb_inside;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               wr_inside;
  logic               take;

  // Map size in use, saturated to the storage size
  assign lim_x = (32'(size_x_q) < GRID_COLS) ? size_x_q : SIZE_W'(GRID_COLS);
  assign lim_y = (32'(size_y_q) < GRID_ROWS) ? size_y_q : SIZE_W'(GRID_ROWS);

  // Neighbour coordinate plus one, so that column minus one stays unsigned
  assign nx_p1 = {1'b0, cx_q} + SIZE_W'(ox_q);
  assign ny_p1 = {1'b0, cy_q} + SIZE_W'(oy_q);
  assign nx    = nx_p1 - SIZE_W'(1);
  assign ny    = ny_p1 - SIZE_W'(1);

  assign nb_inside = (nx_p1 != '0) && (ny_p1 != '0) && (nx < lim_x) && (ny < lim_y);
  assign rd_addr   = ADDR_W'(ny) * ADDR_W'(GRID_COLS) + ADDR_W'(nx);

  assign wr_inside = (32'(cell_x_i) < GRID_COLS) && (32'(cell_y_i) < GRID_ROWS);
  assign wr_addr   = ADDR_W'(cell_y_i) * ADDR_W'(GRID_COLS) + ADDR_W'(cell_x_i);

  assign status_o.last_nb = (ox_q == 2'd2) && (oy_q == 2'd2);

  // Band test on the value read last cycle
  assign take = rd_vld_q && (rd_data_q != '0) && (rd_data_q < upper_limit_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_cell && wr_inside) begin
      mem[wr_addr] <= cell_value_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q      <= SIZE_X_RST;
      size_y_q      <= SIZE_Y_RST;
      upper_limit_q <= UPPER_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SIZE_X:      size_x_q      <= cfg_wdata_i[SIZE_W-1:0];
        CFG_SIZE_Y:      size_y_q      <= cfg_wdata_i[SIZE_W-1:0];
        CFG_UPPER_LIMIT: upper_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q     <= '0;
      oy_q     <= '0;
      rd_vld_q <= 1'b0;
      max_q    <= '0;
    end else begin
      rd_vld_q <= cmd_i.issue && nb_inside;
      if (cmd_i.capture) begin
        ox_q <= '0;
        oy_q <= '0;
      end else if (cmd_i.issue) begin
        if (oy_q == 2'd2) begin
          oy_q <= '0;
          ox_q <= ox_q + 2'd1;
        end else begin
          oy_q <= oy_q + 2'd1;
        end
      end
      if (take && (rd_data_q > max_q)) begin
        max_q <= rd_data_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cx_q  <= cell_x_i;
      cy_q  <= cell_y_i;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (take) begin
      sum_q <= sum_q + SUM_W'(rd_data_q);
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(recip_of(cnt_q));
    end
    if (cmd_i.load_out) begin
      mean_cost_o      <= prod_q[RECIP_SHIFT +: COST_W];
      accepted_count_o <= cnt_q;
      running_max_o    <= max_q;
      none_accepted_o  <= (cnt_q == '0);
    end
  end

endmodule

// File: rtl/core/banded_neighbourhood_mean_with_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banded_neighbourhood_mean_with_max: banded 3x3 mean over a stored cost grid
// Write beats fill the grid; query beats return the mean, count and running
// maximum of the neighbour costs that fall inside the configured band.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per item. A
//   write beat (operation 0) stores cell_value_i at (cell_x_i, cell_y_i) in
//   the accepting cycle and produces no result. A query beat (operation 1)
//   produces exactly one result beat on the output channel.
//   A query reads its nine neighbours one per cycle from the grid memory,
//   so the neighbour scan sets the pace: the result follows the scan, the
//   drain and multiply steps, and the next beat is taken once the block is
//   idle again. Write beats are taken every cycle while no query is active.
//   The output register parts the two sides: while a result waits under
//   out_stall_i the block keeps accepting and working on the next item,
//   and only holds in its final step until the register is free.
//   Configuration writes (cfg_we_i) are registered; issue them only while
//   the block is idle. An index beyond the register list is dropped.
//   Reset clears the running maximum, restores the map size to 64 x 64 and
//   the upper limit to 200.0; the grid contents are undefined until written.
// ----------------------------------------------------------------------------
module banded_neighbourhood_mean_with_max
  import bnmm_pkg::*;
#(
  parameter int unsigned GRID_COLS = 64,
  parameter int unsigned GRID_ROWS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [COORD_W-1:0]    cell_x_i,
  input  logic [COORD_W-1:0]    cell_y_i,
  input  logic [COST_W-1:0]     cell_value_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COST_W-1:0]     mean_cost_o,
  output logic [CNT_W-1:0]      accepted_count_o,
  output logic [COST_W-1:0]     running_max_o,
  output logic                  none_accepted_o,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  // Sequencer: accepts beats, steps the scan, hands results to the output
  bnmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Grid memory, band test, accumulators, reciprocal divide, output payload
  bnmm_datapath #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cell_x_i         (cell_x_i),
    .cell_y_i         (cell_y_i),
    .cell_value_i     (cell_value_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mean_cost_o      (mean_cost_o),
    .accepted_count_o (accepted_count_o),
    .running_max_o    (running_max_o),
    .none_accepted_o  (none_accepted_o)
  );

endmodule
